@@ src/fdma_pkg.sv @@
// shared constants for the frame difference mean accumulator
`timescale 1ns / 1ps

package fdma_pkg;

    localparam int MAX_PIXELS = 65536;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int POS_W      = $clog2(MAX_PIXELS + 1);

    localparam int PIX_W = 8;
    localparam int SUM_W = 16;
    localparam int CNT_W = 16;
    localparam int MEM_W = PIX_W + SUM_W;
    localparam int OUT_POS_W = 16;

    localparam logic [PIX_W-1:0] NOISE_THRESHOLD_RESET = 8'd10;
    localparam logic [PIX_W-1:0] MEAN_MAX = 8'd255;
    localparam logic [SUM_W-1:0] SUM_MAX  = 16'hFFFF;
    localparam logic [CNT_W-1:0] CNT_MAX  = 16'hFFFF;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PIXELS);

endpackage

@@ src/fdma_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module fdma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/frame_difference_mean_accumulator_top.sv @@
// top level: per-pixel thresholded frame difference sum and rounded mean
`timescale 1ns / 1ps
// a last-frame word is read from ram, written back, then goes through an 8-step quotient loop,
// rounding and emit; a saturating quotient goes from the pre-check straight to emit, and a one-frame
// clip goes straight to emit. A first-frame or out-of-range word leaves the input free for the next
// word; other words stall the input for the ram write back, and emit waits on any held result
// reset clears control, position counter and frame count; threshold resets to 10; ram is not cleared

module frame_difference_mean_accumulator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // pixel input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fdma_pkg::PIX_W-1:0]        pixel_value,
    input  logic                              first_frame,
    input  logic                              last_frame,
    input  logic                              end_of_frame,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fdma_pkg::PIX_W-1:0]        mean_motion,
    output logic [fdma_pkg::OUT_POS_W-1:0]    pixel_position,
    // threshold write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fdma_pkg::PIX_W-1:0]        cfg_data
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UPDATE = 3'd1;
    localparam logic [2:0] ST_PRECHK = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_ROUND  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    localparam int SHIFT_W = fdma_pkg::SUM_W + fdma_pkg::PIX_W;

    // control state
    logic [2:0]                     state_reg, state_next;
    logic [fdma_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [fdma_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [fdma_pkg::PIX_W-1:0]     thr_reg, thr_next;
    logic                           out_valid_reg, out_valid_next;
    logic [2:0]                     step_reg, step_next;

    // payload state
    logic [fdma_pkg::PIX_W-1:0]     px_reg, px_next;
    logic                           last_reg, last_next;
    logic [fdma_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [fdma_pkg::CNT_W-1:0]     div_reg, div_next;
    logic [fdma_pkg::SUM_W-1:0]     rem_reg, rem_next;
    logic [fdma_pkg::PIX_W-1:0]     q_reg, q_next;
    logic [fdma_pkg::PIX_W-1:0]     res_reg, res_next;
    logic [fdma_pkg::PIX_W-1:0]     mean_reg, mean_next;
    logic [fdma_pkg::OUT_POS_W-1:0] opos_reg, opos_next;

    // ram port
    logic                           ram_wr_en;
    logic [fdma_pkg::ADDR_W-1:0]    ram_wr_addr;
    logic [fdma_pkg::MEM_W-1:0]     ram_wr_data;
    logic                           ram_rd_en;
    logic [fdma_pkg::MEM_W-1:0]     ram_rd_data;

    // datapath helpers
    logic                           in_accept;
    logic                           in_range;
    logic                           out_free;
    logic [fdma_pkg::ADDR_W-1:0]    cur_addr;
    logic [fdma_pkg::PIX_W-1:0]     old_px;
    logic [fdma_pkg::SUM_W-1:0]     old_sum;
    logic [fdma_pkg::PIX_W-1:0]     abs_diff;
    logic [fdma_pkg::PIX_W-1:0]     thr_diff;
    logic [fdma_pkg::SUM_W:0]       sum_wide;
    logic [fdma_pkg::SUM_W-1:0]     sum_sat;
    logic [SHIFT_W-1:0]             div_shift;
    logic [SHIFT_W-1:0]             rem_wide;
    logic [fdma_pkg::SUM_W:0]       rem_x2;
    logic                           round_up;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_range = (pos_reg < fdma_pkg::POS_LIMIT);
    assign cur_addr = pos_reg[fdma_pkg::ADDR_W-1:0];

    // ram word: previous pixel in the upper byte, running sum below
    assign old_px  = ram_rd_data[fdma_pkg::MEM_W-1:fdma_pkg::SUM_W];
    assign old_sum = ram_rd_data[fdma_pkg::SUM_W-1:0];

    assign abs_diff = (px_reg > old_px) ? (px_reg - old_px) : (old_px - px_reg);
    assign thr_diff = (abs_diff <= thr_reg) ? '0 : abs_diff;
    assign sum_wide = {1'b0, old_sum} + {{(fdma_pkg::SUM_W + 1 - fdma_pkg::PIX_W){1'b0}}, thr_diff};
    assign sum_sat  = sum_wide[fdma_pkg::SUM_W] ? fdma_pkg::SUM_MAX
                                                : sum_wide[fdma_pkg::SUM_W-1:0];

    // restoring division, one quotient bit per cycle
    assign div_shift = {{fdma_pkg::PIX_W{1'b0}}, div_reg} << step_reg;
    assign rem_wide  = {{fdma_pkg::PIX_W{1'b0}}, rem_reg};

    // round half to even on the final remainder
    assign rem_x2   = {rem_reg, 1'b0};
    assign round_up = (rem_x2 > {1'b0, div_reg})
                   || ((rem_x2 == {1'b0, div_reg}) && q_reg[0]);

    // ram write: store on first frame at accept, write back in update
    always_comb
    begin
        ram_rd_en   = in_accept && in_range && !first_frame;
        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_addr;
        ram_wr_data = {pixel_value, {fdma_pkg::SUM_W{1'b0}}};
        if (state_reg == ST_UPDATE)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_reg;
            ram_wr_data = {px_reg, sum_sat};
        end
        else if (in_accept && in_range && first_frame)
        begin
            ram_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg;
        step_next      = step_reg;
        px_next        = px_reg;
        last_next      = last_reg;
        addr_next      = addr_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        mean_next      = mean_reg;
        opos_next      = opos_reg;

        if (cfg_valid && cfg_ready)
        begin
            thr_next = cfg_data;
        end

        // result register drains independently of the sequencer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    px_next   = pixel_value;
                    last_next = last_frame;
                    addr_next = cur_addr;
                    // divisor is frame count plus one, saturated
                    div_next  = (cnt_reg == fdma_pkg::CNT_MAX) ? fdma_pkg::CNT_MAX
                                                               : cnt_reg + 1'b1;
                    // frame count and raster position
                    if (end_of_frame)
                    begin
                        pos_next = '0;
                        if (first_frame)
                        begin
                            cnt_next = '0;
                        end
                        else if (cnt_reg != fdma_pkg::CNT_MAX)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (first_frame)
                        begin
                            cnt_next = '0;
                        end
                        if (in_range)
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    if (in_range)
                    begin
                        if (first_frame)
                        begin
                            if (last_frame)
                            begin
                                // one-frame clip reports zero motion
                                res_next   = '0;
                                state_next = ST_EMIT;
                            end
                        end
                        else
                        begin
                            state_next = ST_UPDATE;
                        end
                    end
                end
            end

            ST_UPDATE:
            begin
                rem_next = sum_sat;
                state_next = last_reg ? ST_PRECHK : ST_IDLE;
            end

            ST_PRECHK:
            begin
                // quotient of 256 or more saturates straight away
                if (rem_wide >= {div_reg, {fdma_pkg::PIX_W{1'b0}}})
                begin
                    res_next   = fdma_pkg::MEAN_MAX;
                    state_next = ST_EMIT;
                end
                else
                begin
                    q_next     = '0;
                    step_next  = 3'd7;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (rem_wide >= div_shift)
                begin
                    rem_next         = fdma_pkg::SUM_W'(rem_wide - div_shift);
                    q_next[step_reg] = 1'b1;
                end
                if (step_reg == 3'd0)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            ST_ROUND:
            begin
                if (round_up && (q_reg != fdma_pkg::MEAN_MAX))
                begin
                    res_next = q_reg + 1'b1;
                end
                else
                begin
                    res_next = q_reg;
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mean_next      = res_reg;
                    opos_next      = fdma_pkg::OUT_POS_W'(addr_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            thr_reg       <= fdma_pkg::NOISE_THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        last_reg <= last_next;
        addr_reg <= addr_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
        mean_reg <= mean_next;
        opos_reg <= opos_next;
    end

    assign out_valid      = out_valid_reg;
    assign mean_motion    = mean_reg;
    assign pixel_position = opos_reg;

    // previous pixel and running sum share one word per position
    fdma_ram #(
        .WIDTH (fdma_pkg::MEM_W),
        .DEPTH (fdma_pkg::MAX_PIXELS)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cur_addr),
        .rd_data (ram_rd_data)
    );

endmodule
